### design/kuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants of the kruskal union-find edge filter.
// ----------------------------------------------------------------------------
package kuf_pkg;

  localparam int NODE_W    = 10;
  localparam int DIST_W    = 32;
  localparam int CFG_W     = 11;
  localparam int ACC_CNT_W = 10;
  localparam int RANK_W    = 4;
  localparam int EPOCH_W   = 8;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [RANK_W-1:0] RANK_MAX       = 4'd15;
  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 11'd1024;
  localparam logic              REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED  = 2'd0,
    STATUS_REJECTED  = 2'd1,
    STATUS_DISCARDED = 2'd2
  } edge_status_t;

  typedef struct packed {
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic [DIST_W-1:0] edge_distance;
    logic              first_edge;
  } in_req_t;

  typedef struct packed {
    edge_status_t         edge_status;
    logic [DIST_W-1:0]    echoed_distance;
    logic                 tree_complete;
    logic [ACC_CNT_W-1:0] accepted_count;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CHECK,
    ST_WALK,
    ST_COMP,
    ST_TURN,
    ST_LINK,
    ST_BUMP,
    ST_DONE
  } kuf_state_t;

endpackage

### design/kuf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module kuf_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/kuf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_cfg
// APB register file holding the node count.
// ----------------------------------------------------------------------------
module kuf_cfg import kuf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CFG_W-1:0]  node_count
);

  logic [CFG_W-1:0] node_count_r;
  logic             sel_node_count;

  assign sel_node_count = (paddr[APB_AW-1] == REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && sel_node_count) begin
      node_count_r <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata     = sel_node_count ? APB_DW'(node_count_r) : '0;
  assign pready     = 1'b1;
  assign node_count = node_count_r;

endmodule

### design/kuf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_engine
// Union-find sequencer: walks, compresses and links forest entries in the RAM.
// ----------------------------------------------------------------------------
module kuf_engine import kuf_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           start,
  output logic                                           busy,
  input  in_req_t                                        in_data,
  input  logic [CFG_W-1:0]                               node_count,
  output logic                                           out_valid,
  output out_res_t                                       out_data,
  output logic                                           ram_wr_en,
  output logic [$clog2(MAX_NODES)-1:0]                   ram_wr_addr,
  output logic [EPOCH_W+$clog2(MAX_NODES)+RANK_W-1:0]    ram_wr_data,
  output logic                                           ram_rd_en,
  output logic [$clog2(MAX_NODES)-1:0]                   ram_rd_addr,
  input  logic [EPOCH_W+$clog2(MAX_NODES)+RANK_W-1:0]    ram_rd_data
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);
  localparam logic [NW-1:0]    MAX_N    = NW'(MAX_NODES);
  localparam logic [NW-1:0]    MIN_N    = NW'(2);

  kuf_state_t state_r, state_nxt;

  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [IDX_W-1:0]   sweep_r, sweep_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               complete_r, complete_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [NODE_W-1:0]  src_r, src_nxt;
  logic [NODE_W-1:0]  dst_r, dst_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic               side_r, side_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   x_r, x_nxt;
  logic [IDX_W-1:0]   root_a_r, root_a_nxt;
  logic [RANK_W-1:0]  rank_a_r, rank_a_nxt;
  logic [RANK_W-1:0]  rank_b_r, rank_b_nxt;
  edge_status_t       status_r, status_nxt;
  out_res_t           out_data_r, out_data_nxt;
  logic [IDX_W-1:0]   rdq_addr_r;

  // decoded read data, stale epoch reads as a fresh singleton
  logic [EPOCH_W-1:0] rd_tag;
  logic [IDX_W-1:0]   rd_parent;
  logic [RANK_W-1:0]  rd_rank;
  logic               hit;
  logic [IDX_W-1:0]   eff_parent;
  logic [RANK_W-1:0]  eff_rank;

  logic [NW-1:0]      nc_ext, n_eff, lim, cnt_ext, inc_ext, src_ext, dst_ext;
  logic [CNT_W-1:0]   count_inc;
  logic [IDX_W-1:0]   src_a, dst_a, start_node;
  logic               par_is_cur, early_done, out_range, same_root, a_wins, bump_needed;
  logic               epoch_wrap, sweep_end;

  assign rd_tag    = ram_rd_data[EPOCH_W+IDX_W+RANK_W-1 -: EPOCH_W];
  assign rd_parent = ram_rd_data[IDX_W+RANK_W-1:RANK_W];
  assign rd_rank   = ram_rd_data[RANK_W-1:0];
  assign hit       = (rd_tag == epoch_r);
  assign eff_parent = hit ? rd_parent : rdq_addr_r;
  assign eff_rank   = hit ? rd_rank : '0;

  assign nc_ext  = NW'(node_count);
  always_comb begin
    priority if (nc_ext < MIN_N) begin
      n_eff = MIN_N;
    end else if (nc_ext > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = nc_ext;
    end
  end
  assign lim       = n_eff - NW'(1);
  assign cnt_ext   = NW'(count_r);
  assign count_inc = count_r + CNT_W'(1);
  assign inc_ext   = NW'(count_inc);
  assign src_ext   = NW'(src_r);
  assign dst_ext   = NW'(dst_r);
  assign src_a     = src_ext[IDX_W-1:0];
  assign dst_a     = dst_ext[IDX_W-1:0];
  assign start_node = side_r ? dst_a : src_a;

  assign par_is_cur  = (eff_parent == cur_r);
  assign early_done  = complete_r || (cnt_ext >= lim);
  assign out_range   = (src_ext >= n_eff) || (dst_ext >= n_eff);
  assign same_root   = (root_a_r == cur_r);
  assign a_wins      = (rank_a_r > rank_b_r);
  assign bump_needed = (rank_a_r == rank_b_r) && (rank_b_r != RANK_MAX);
  assign epoch_wrap  = (epoch_r == '1);
  assign sweep_end   = (sweep_r == LAST_IDX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.first_edge && epoch_wrap) ? ST_SWEEP : ST_CHECK;
        end
      end
      ST_SWEEP: begin
        if (sweep_end) begin
          state_nxt = pend_r ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_nxt = (early_done || out_range) ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (par_is_cur) begin
          state_nxt = (start_node == cur_r) ? ST_TURN : ST_COMP;
        end
      end
      ST_COMP: begin
        if (par_is_cur) begin
          state_nxt = ST_TURN;
        end
      end
      ST_TURN: begin
        state_nxt = side_r ? ST_LINK : ST_WALK;
      end
      ST_LINK: begin
        priority if (same_root) begin
          state_nxt = ST_DONE;
        end else if (!a_wins && bump_needed) begin
          state_nxt = ST_BUMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BUMP: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    epoch_nxt     = epoch_r;
    sweep_nxt     = sweep_r;
    count_nxt     = count_r;
    complete_nxt  = complete_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    dist_nxt      = dist_r;
    side_nxt      = side_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    root_a_nxt    = root_a_r;
    rank_a_nxt    = rank_a_r;
    rank_b_nxt    = rank_b_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cur_r;
    ram_wr_data   = {epoch_r, cur_r, rank_b_r};
    ram_rd_en     = 1'b0;
    ram_rd_addr   = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          src_nxt  = in_data.source_node;
          dst_nxt  = in_data.target_node;
          dist_nxt = in_data.edge_distance;
          pend_nxt = 1'b1;
          if (in_data.first_edge) begin
            count_nxt    = '0;
            complete_nxt = 1'b0;
            epoch_nxt    = epoch_r + EPOCH_W'(1);
            sweep_nxt    = '0;
          end
        end
      end
      ST_SWEEP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = sweep_r;
        ram_wr_data = {{EPOCH_W{1'b0}}, sweep_r, {RANK_W{1'b0}}};
        sweep_nxt   = sweep_r + IDX_W'(1);
      end
      ST_CHECK: begin
        side_nxt = 1'b0;
        priority if (early_done) begin
          complete_nxt = 1'b1;
          status_nxt   = STATUS_DISCARDED;
        end else if (out_range) begin
          status_nxt = STATUS_REJECTED;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = src_a;
          cur_nxt     = src_a;
        end
      end
      ST_WALK: begin
        if (par_is_cur) begin
          if (side_r) begin
            rank_b_nxt = eff_rank;
          end else begin
            rank_a_nxt = eff_rank;
          end
          if (start_node != cur_r) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = start_node;
            x_nxt       = start_node;
          end
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = eff_parent;
          cur_nxt     = eff_parent;
        end
      end
      ST_COMP: begin
        // point x at the root, read its old parent in the same cycle
        ram_wr_en   = 1'b1;
        ram_wr_addr = x_r;
        ram_wr_data = {epoch_r, cur_r, eff_rank};
        if (!par_is_cur) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = eff_parent;
          x_nxt       = eff_parent;
        end
      end
      ST_TURN: begin
        if (!side_r) begin
          root_a_nxt  = cur_r;
          side_nxt    = 1'b1;
          ram_rd_en   = 1'b1;
          ram_rd_addr = dst_a;
          cur_nxt     = dst_a;
        end
      end
      ST_LINK: begin
        if (same_root) begin
          status_nxt = STATUS_REJECTED;
        end else begin
          status_nxt = STATUS_ACCEPTED;
          count_nxt  = count_inc;
          if (inc_ext >= lim) begin
            complete_nxt = 1'b1;
          end
          ram_wr_en = 1'b1;
          if (a_wins) begin
            ram_wr_addr = cur_r;
            ram_wr_data = {epoch_r, root_a_r, rank_b_r};
          end else begin
            ram_wr_addr = root_a_r;
            ram_wr_data = {epoch_r, cur_r, rank_a_r};
          end
        end
      end
      ST_BUMP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cur_r;
        ram_wr_data = {epoch_r, cur_r, rank_b_r + RANK_W'(1)};
      end
      ST_DONE: begin
        out_valid_nxt                = 1'b1;
        pend_nxt                     = 1'b0;
        out_data_nxt.edge_status     = status_r;
        out_data_nxt.echoed_distance = dist_r;
        out_data_nxt.tree_complete   = complete_r;
        out_data_nxt.accepted_count  = ACC_CNT_W'(count_r);
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      epoch_r     <= '0;
      sweep_r     <= '0;
      count_r     <= '0;
      complete_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      complete_r  <= complete_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    dist_r     <= dist_nxt;
    side_r     <= side_nxt;
    cur_r      <= cur_nxt;
    x_r        <= x_nxt;
    root_a_r   <= root_a_nxt;
    rank_a_r   <= rank_a_nxt;
    rank_b_r   <= rank_b_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    if (ram_rd_en) begin
      rdq_addr_r <= ram_rd_addr;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/kruskal_union_find_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Kruskal spanning-tree edge filter over a union-find forest held in one RAM.
//
//   channel   ports                         handshake
//   --------  ----------------------------  ------------------------------
//   request   start, busy, in_data          taken when start && !busy
//   result    out_valid, out_data           one-cycle strobe, no stall
//   config    psel..pready (APB)            write on psel&penable&pwrite
//
// a discarded or out-of-range request visits only the check and done states;
// any other walks and compresses both endpoint paths, links the two roots and
// bumps the rank when it grows. the result strobe rises in the same cycle as
// busy falls. one forest entry is read or rewritten per cycle while walking
// and compressing. after reset a clearing pass over all MAX_NODES entries runs
// while busy is high; the same pass runs again on every 256th first-edge
// request, when the tree epoch tag wraps. results cannot be stalled.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter import kuf_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_data,
  output logic              out_valid,
  output out_res_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int EW    = EPOCH_W + IDX_W + RANK_W;

  logic [CFG_W-1:0] node_count;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [EW-1:0]    ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [EW-1:0]    ram_rd_data;

  kuf_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  kuf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_forest_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  kuf_engine #(
    .MAX_NODES (MAX_NODES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .node_count  (node_count),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule
